// ----- rtl/sha512_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// sha512_pkg
// shared types, constants and round functions of the sha-512 core
// ============================================================================
package sha512_pkg;

    typedef logic [63:0] word_t;

    // front to back queue entry
    typedef struct packed {
        logic [63:0] data_word;
        logic [3:0]  byte_count;
        logic        last;
    } item_t;

    localparam int QUEUE_DEPTH = 2;
    localparam int ROUNDS      = 80;

    localparam word_t IV_TABLE [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
        64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam word_t K_TABLE [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    function automatic word_t rotr(input word_t x, input int n);
        rotr = (x >> n) | (x << (64 - n));
    endfunction

    function automatic word_t sig0(input word_t x);
        sig0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
    endfunction

    function automatic word_t sig1(input word_t x);
        sig1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
    endfunction

    function automatic word_t bsig0(input word_t x);
        bsig0 = rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
    endfunction

    function automatic word_t bsig1(input word_t x);
        bsig1 = rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
    endfunction

endpackage

// ----- rtl/sha512_queue.sv -----
`timescale 1ns / 1ps
// ============================================================================
// sha512_queue
// small item queue between the input front end and the hash engine
// ============================================================================
module sha512_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_valid,
    output logic                wr_stall,
    input  sha512_pkg::item_t   wr_item,
    output logic                rd_valid,
    input  logic                rd_stall,
    output sha512_pkg::item_t   rd_item
);
    import sha512_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    item_t           mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wp_reg;
    logic [PW-1:0]   rp_reg;
    logic [PW:0]     cnt_reg;
    logic            push;
    logic            pop;

    assign wr_stall = (cnt_reg == (PW+1)'(QUEUE_DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_item  = mem_reg[rp_reg];
    assign push     = wr_valid && !wr_stall;
    assign pop      = rd_valid && !rd_stall;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (PW+1)'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
    a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("queue count lost a push");
    a_cnt_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> cnt_reg == $past(cnt_reg) - 1'b1)
        else $error("queue count lost a pop");
`endif

endmodule

// ----- rtl/sha512_engine.sv -----
`timescale 1ns / 1ps
// ============================================================================
// sha512_engine
// block assembly, padding, 80-round compression and digest output
// ============================================================================
module sha512_engine (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  sha512_pkg::item_t   in_item,
    output logic                digest_valid,
    input  logic                digest_stall,
    output logic [63:0]         digest_word,
    output logic                digest_last
);
    import sha512_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PUSH = 3'd1;
    localparam logic [2:0] ST_RND  = 3'd2;
    localparam logic [2:0] ST_ADD  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    // pending word sources after a last item
    localparam logic [1:0] PS_PAD  = 2'd0;
    localparam logic [1:0] PS_ZERO = 2'd1;
    localparam logic [1:0] PS_LEN  = 2'd2;
    localparam logic [1:0] PS_DONE = 2'd3;

    logic [2:0]  state_reg;
    logic [1:0]  ps_reg;
    logic        fin_reg;
    word_t       h_reg [8];
    word_t       v_reg [8];
    word_t       w_reg [16];
    logic [3:0]  slot_reg;
    logic [6:0]  rnd_reg;
    logic [63:0] bits_reg;
    logic [2:0]  oidx_reg;

    word_t       push_word;
    logic        push_en;
    word_t       w_cur;
    word_t       t1;
    word_t       t2;
    logic [3:0]  cnt;
    word_t       mask;
    word_t       padw;
    logic        take;

    always_comb
    begin
        cnt = in_item.byte_count;
        if (cnt > 4'd8 || !in_item.last)
        begin
            cnt = 4'd8;
        end
        mask = (cnt == 4'd0) ? 64'd0 : ~(~64'd0 >> {cnt[3:0], 3'b000});
        padw = (in_item.data_word & mask) | ({56'd0, PAD_BYTE} << (7'd56 - {cnt, 3'b000}));
    end

    assign in_stall = (state_reg != ST_IDLE);
    assign take     = in_valid && !in_stall;

    // schedule word for this round
    always_comb
    begin
        if (rnd_reg < 7'd16)
        begin
            w_cur = w_reg[0];
        end
        else
        begin
            w_cur = w_reg[0] + sig0(w_reg[1]) + w_reg[9] + sig1(w_reg[14]);
        end
        t1 = v_reg[7] + bsig1(v_reg[4]) + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
             + K_TABLE[rnd_reg] + w_cur;
        t2 = bsig0(v_reg[0]) + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2])
             ^ (v_reg[1] & v_reg[2]));
    end

    // word pushed into the block this cycle
    always_comb
    begin
        push_en   = 1'b0;
        push_word = '0;
        if (take)
        begin
            push_en   = 1'b1;
            push_word = in_item.last ? ((cnt == 4'd8) ? in_item.data_word : padw)
                                     : in_item.data_word;
        end
        else if (state_reg == ST_PUSH)
        begin
            push_en = 1'b1;
            case (ps_reg)
                PS_PAD:  push_word = {PAD_BYTE, 56'd0};
                PS_ZERO: push_word = '0;
                PS_LEN:  push_word = bits_reg;
                default: push_word = '0;
            endcase
        end
    end

    assign digest_valid = (state_reg == ST_OUT);
    assign digest_word  = h_reg[oidx_reg];
    assign digest_last  = (oidx_reg == 3'd7);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            ps_reg       <= PS_DONE;
            fin_reg      <= 1'b0;
            slot_reg     <= '0;
            rnd_reg      <= '0;
            bits_reg     <= '0;
            oidx_reg     <= '0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= IV_TABLE[i];
                v_reg[i] <= '0;
            end
        end
        else
        begin
            if (take)
            begin
                bits_reg <= bits_reg + {57'd0, cnt, 3'b000};
                fin_reg  <= in_item.last;
                if (in_item.last)
                begin
                    ps_reg       <= (cnt == 4'd8) ? PS_PAD : PS_ZERO;
                end
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (take)
                    begin
                        if (slot_reg == 4'd15)
                        begin
                            state_reg <= ST_RND;
                            for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
                        end
                        else if (in_item.last)
                        begin
                            state_reg <= ST_PUSH;
                        end
                    end
                end
                ST_PUSH:
                begin
                    if (ps_reg == PS_PAD)
                    begin
                        ps_reg <= PS_ZERO;
                    end
                    else if (ps_reg == PS_ZERO && slot_reg == 4'd14)
                    begin
                        ps_reg <= PS_LEN;
                    end
                    else if (ps_reg == PS_LEN)
                    begin
                        ps_reg <= PS_DONE;
                    end
                    if (slot_reg == 4'd15)
                    begin
                        state_reg <= ST_RND;
                        for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
                    end
                end
                ST_RND:
                begin
                    v_reg[7] <= v_reg[6];
                    v_reg[6] <= v_reg[5];
                    v_reg[5] <= v_reg[4];
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[3] <= v_reg[2];
                    v_reg[2] <= v_reg[1];
                    v_reg[1] <= v_reg[0];
                    v_reg[0] <= t1 + t2;
                    if (rnd_reg == 7'(ROUNDS - 1))
                    begin
                        rnd_reg   <= '0;
                        state_reg <= ST_ADD;
                    end
                    else
                    begin
                        rnd_reg <= rnd_reg + 1'b1;
                    end
                end
                ST_ADD:
                begin
                    for (int i = 0; i < 8; i++) h_reg[i] <= h_reg[i] + v_reg[i];
                    if (!fin_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (ps_reg == PS_DONE)
                    begin
                        state_reg <= ST_OUT;
                        oidx_reg  <= '0;
                    end
                    else
                    begin
                        state_reg <= ST_PUSH;
                    end
                end
                ST_OUT:
                begin
                    if (!digest_stall)
                    begin
                        oidx_reg <= oidx_reg + 1'b1;
                        if (oidx_reg == 3'd7)
                        begin
                            state_reg <= ST_IDLE;
                            fin_reg   <= 1'b0;
                            bits_reg  <= '0;
                            slot_reg  <= '0;
                            for (int i = 0; i < 8; i++) h_reg[i] <= IV_TABLE[i];
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
            if (push_en)
            begin
                slot_reg <= slot_reg + 1'b1;
            end
        end
    end

    // window: round form shifts left, push form writes the slot
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_RND)
        begin
            for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
            w_reg[15] <= w_cur;
        end
        else if (push_en)
        begin
            w_reg[slot_reg] <= push_word;
        end
    end

`ifndef SYNTH
    a_out_only_final: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid |-> fin_reg)
        else $error("digest shown without a final block");
    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        rnd_reg < 7'(ROUNDS))
        else $error("round counter out of range");
    a_rnd_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_RND) |-> rnd_reg == '0)
        else $error("round counter left nonzero");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (digest_valid && digest_stall) |=> digest_valid && $stable(oidx_reg))
        else $error("digest index moved under stall");
`endif

endmodule

// ----- rtl/sha512_hash_core_unit.sv -----
`timescale 1ns / 1ps
// ============================================================================
// sha512_hash_core_unit
// sha-512 hash over big-endian 64-bit message words
// ============================================================================
// Words enter through a two-entry queue and are written into the sixteen-word
// block window, one per cycle while the engine is idle; a full block then
// runs 80 rounds, one per cycle in a single round unit, and is added into
// the hash state before the engine takes a new word. The word marked last
// triggers padding at one word per cycle between compressions, one or two final
// compressions and eight digest words H0..H7, the last flagged by digest_last.
module sha512_hash_core_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid,
    output logic        stall,
    input  logic [63:0] data_word,
    input  logic [3:0]  byte_count,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] digest_word,
    output logic        digest_last
);
    import sha512_pkg::*;

    item_t in_item;
    item_t q_item;
    logic  q_valid;
    logic  q_stall;

    assign in_item = '{data_word: data_word, byte_count: byte_count, last: last};

    sha512_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (valid),
        .wr_stall (stall),
        .wr_item  (in_item),
        .rd_valid (q_valid),
        .rd_stall (q_stall),
        .rd_item  (q_item)
    );

    sha512_engine u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (q_valid),
        .in_stall     (q_stall),
        .in_item      (q_item),
        .digest_valid (out_valid),
        .digest_stall (out_stall),
        .digest_word  (digest_word),
        .digest_last  (digest_last)
    );

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ============================================================================
// testbench
// sha-512 core check against a behavioral digest predictor
// ============================================================================
// Messages of random length and content are fed word by word with random gaps
// on both handshakes; every digest word is compared with the predicted one.
module testbench;
    import sha512_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        valid;
    logic        stall;
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        last;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] digest_word;
    logic        digest_last;

    typedef struct {
        logic [63:0] digest_word;
        logic        digest_last;
    } digest_t;

    item_t   pending_words[$];
    digest_t expected_digest[$];
    int      error_count;
    bit      stim_done;
    bit      hold_rx;
    int      rx_hold_cycles;
    int      tx_gap;
    int      rx_gap;

    // predictor state
    logic [63:0] hv[8];
    logic [63:0] blk[16];
    int          slot;
    logic [63:0] bit_len;

    sha512_hash_core_unit u_dut (
        .clk(clk), .rst_n(rst_n), .valid(valid), .stall(stall),
        .data_word(data_word), .byte_count(byte_count), .last(last),
        .out_valid(out_valid), .out_stall(out_stall),
        .digest_word(digest_word), .digest_last(digest_last)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic logic [63:0] ror(logic [63:0] x, int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    task automatic compress_block();
        logic [63:0] w[16];
        logic [63:0] v[8];
        logic [63:0] wt, t1, t2, a, e, x15, x2;
        for (int i = 0; i < 16; i++) w[i] = blk[i];
        for (int i = 0; i < 8; i++) v[i] = hv[i];
        for (int t = 0; t < 80; t++)
        begin
            if (t < 16)
                wt = w[t];
            else
            begin
                x15 = w[(t - 15) & 15];
                x2  = w[(t - 2) & 15];
                wt = w[t & 15] + (ror(x15, 1) ^ ror(x15, 8) ^ (x15 >> 7))
                   + w[(t - 7) & 15] + (ror(x2, 19) ^ ror(x2, 61) ^ (x2 >> 6));
                w[t & 15] = wt;
            end
            a = v[0];
            e = v[4];
            t1 = v[7] + (ror(e, 14) ^ ror(e, 18) ^ ror(e, 41))
               + ((e & v[5]) ^ (~e & v[6])) + K_TABLE[t] + wt;
            t2 = (ror(a, 28) ^ ror(a, 34) ^ ror(a, 39))
               + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hv[i] += v[i];
    endtask

    task automatic absorb_word(logic [63:0] w);
        blk[slot] = w;
        slot = (slot + 1) & 15;
        if (slot == 0)
            compress_block();
    endtask

    task automatic predict_word(item_t it);
        int          n;
        logic [63:0] mask;
        digest_t     d;
        n = it.byte_count;
        if (n > 8 || !it.last)
            n = 8;
        bit_len += 64'(n * 8);
        if (!it.last)
        begin
            absorb_word(it.data_word);
            return;
        end
        if (n == 8)
        begin
            absorb_word(it.data_word);
            absorb_word({PAD_BYTE, 56'h0});
        end
        else
        begin
            mask = (n == 0) ? 64'h0 : ~(~64'h0 >> (8 * n));
            absorb_word((it.data_word & mask) | ({56'h0, PAD_BYTE} << (56 - 8 * n)));
        end
        while (slot != 14)
            absorb_word(64'h0);
        absorb_word(64'h0);
        absorb_word(bit_len);
        for (int i = 0; i < 8; i++)
        begin
            d.digest_word = hv[i];
            d.digest_last = (i == 7);
            expected_digest.push_back(d);
        end
        for (int i = 0; i < 8; i++) hv[i] = IV_TABLE[i];
        bit_len = 64'h0;
        slot = 0;
    endtask

    function automatic int pick_gap();
        if ($urandom_range(0, 3) == 0)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    function automatic item_t make_word(logic [63:0] dw, int cnt, bit lst);
        item_t it;
        it.data_word = dw;
        it.byte_count = 4'(cnt);
        it.last = lst;
        return it;
    endfunction

    function automatic logic [63:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid <= 1'b0;
            data_word <= '0;
            byte_count <= '0;
            last <= 1'b0;
            tx_gap <= 0;
        end
        else
        begin
            automatic bit taken = valid && !stall;
            if (taken)
                predict_word('{data_word, byte_count, last});
            if (valid && !taken)
                ;
            else if (tx_gap > 0)
            begin
                valid <= 1'b0;
                tx_gap <= tx_gap - 1;
            end
            else if (pending_words.size() > 0 && pending_words[0].byte_count === 4'hx)
            begin
                // pause marker: wait until all digests are back
                valid <= 1'b0;
                if (expected_digest.size() == 0 && !(taken && last))
                    void'(pending_words.pop_front());
            end
            else if (pending_words.size() > 0)
            begin
                automatic item_t it = pending_words.pop_front();
                valid <= 1'b1;
                data_word <= it.data_word;
                byte_count <= it.byte_count;
                last <= it.last;
                tx_gap <= pick_gap();
            end
            else
                valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            rx_gap <= 0;
            rx_hold_cycles <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_digest.size() == 0)
                begin
                    $error("unexpected digest word %h", digest_word);
                    error_count++;
                end
                else
                begin
                    automatic digest_t d = expected_digest.pop_front();
                    if (digest_word !== d.digest_word)
                    begin
                        $error("digest_word expected %h actual %h", d.digest_word,
                               digest_word);
                        error_count++;
                    end
                    if (digest_last !== d.digest_last)
                    begin
                        $error("digest_last expected %b actual %b", d.digest_last,
                               digest_last);
                        error_count++;
                    end
                end
            end
            if (rx_hold_cycles > 0)
            begin
                out_stall <= 1'b1;
                rx_hold_cycles <= rx_hold_cycles - 1;
            end
            else if (hold_rx)
            begin
                out_stall <= 1'b1;
                rx_hold_cycles <= 600;
            end
            else if (rx_gap > 0)
            begin
                out_stall <= 1'b1;
                rx_gap <= rx_gap - 1;
            end
            else
            begin
                out_stall <= 1'b0;
                rx_gap <= pick_gap();
            end
        end
    end

    task automatic queue_message(int nbytes);
        int full;
        int rem;
        full = nbytes / 8;
        rem = nbytes % 8;
        for (int i = 0; i < full; i++)
            pending_words.push_back(make_word(rand_word(), 8, (rem == 0) && (i == full - 1)
                                    && ($urandom_range(0, 1) == 0)));
        if (pending_words.size() > 0 && pending_words[$].last)
            return;
        pending_words.push_back(make_word(rand_word(), rem, 1'b1));
    endtask

    task automatic queue_pause();
        item_t it;
        it.data_word = '0;
        it.byte_count = 4'bx;
        it.last = 1'b0;
        pending_words.push_back(it);
    endtask

    initial
    begin
        int words;
        error_count = 0;
        stim_done = 0;
        hold_rx = 0;
        slot = 0;
        bit_len = 64'h0;
        for (int i = 0; i < 8; i++) hv[i] = IV_TABLE[i];
        for (int i = 0; i < 16; i++) blk[i] = '0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty message, extremes, count saturation, short words
        pending_words.push_back(make_word(64'h0, 0, 1'b1));
        pending_words.push_back(make_word(~64'h0, 8, 1'b1));
        pending_words.push_back(make_word(64'h0, 8, 1'b1));
        pending_words.push_back(make_word(~64'h0, 15, 1'b1));
        pending_words.push_back(make_word(64'h8081828384858687, 9, 1'b1));
        pending_words.push_back(make_word(64'hffeeddccbbaa9988, 3, 1'b0));
        pending_words.push_back(make_word(~64'h0, 7, 1'b1));
        pending_words.push_back(make_word(64'h6162638000000000, 3, 1'b1));
        for (int i = 0; i < 14; i++)
            pending_words.push_back(make_word(rand_word(), 8, 1'b0));
        pending_words.push_back(make_word(~64'h0, 1, 1'b1));
        queue_pause();
        for (int i = 0; i < 15; i++)
            pending_words.push_back(make_word(rand_word(), 8, 1'b0));
        pending_words.push_back(make_word(rand_word(), 8, 1'b1));

        // random messages, mostly short, a few spanning several blocks
        words = 0;
        while (words < 150)
        begin
            automatic int len = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                            : $urandom_range(0, 60);
            words += len / 8 + 1;
            queue_message(len);
            if ($urandom_range(0, 9) == 0)
                queue_pause();
        end
        wait (pending_words.size() < 120);
        hold_rx = 1;
        wait (rx_hold_cycles > 0);
        hold_rx = 0;
        wait (pending_words.size() == 0);
        @(posedge clk);
        while (valid)
            @(posedge clk);
        wait (expected_digest.size() == 0);
        repeat (200) @(posedge clk);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end
endmodule
